// File: rtl/frcp_pkg.sv
// Shared constants and types for the font ROM card command port.
package frcp_pkg;

    // Port addresses (low byte of the I/O address)
    localparam logic [7:0] PORT_DATA   = 8'hFC;
    localparam logic [7:0] PORT_STATUS = 8'hFD;

    // Access kinds
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // Fixed byte values
    localparam logic [7:0] HEADER_BYTE  = 8'h40;
    localparam logic [7:0] STATUS_READY = 8'h81;
    localparam logic [7:0] STATUS_ERROR = 8'h02;
    localparam logic [7:0] STATUS_IDLE  = 8'h00;
    localparam logic [7:0] OTHER_READ   = 8'hFF;
    localparam logic [7:0] EMPTY_READ   = 8'h00;
    localparam logic [7:0] ROM_FILL     = 8'hFF;

    // Command byte sequence: mode, code low, code high
    typedef enum logic [2:0] {
        CMD_MODE = 3'b001,
        CMD_LOW  = 3'b010,
        CMD_HIGH = 3'b100
    } t_cmd_phase;

endpackage

// File: rtl/frcp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module frcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/font_rom_card_command_port_unit.sv
// Font ROM card command port: command decode, glyph queue and status/irq handling.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------
//  access  | in        | i_valid / o_stall   | i_action, i_port, i_write_data
//  result  | out       | o_valid / i_stall   | o_read_data, o_irq_level
//
// One request per cycle is accepted while o_stall is low. Acceptance reads the ROM
// and loads the middle stage, which moves to the output register when not stalled.
// The font ROM is one synchronous RAM, read on every accepted request.
// After reset the ROM is filled with 0xFF, one byte a cycle, over all ROM_DEPTH
// addresses (92160 by default); o_stall stays high during the fill.
// A stalled output holds the next result in the middle stage; o_stall rises during
// the ROM fill, or when both stages are full and the output is stalled.
module font_rom_card_command_port_unit #(
    parameter int GLYPH_BYTES = 36,
    parameter int FIRST_CODE  = 512,
    parameter int END_CODE    = 3072,
    parameter int ROM_DEPTH   = 92160
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_action,
    input  logic [7:0] i_port,
    input  logic [7:0] i_write_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_read_data,
    output logic       o_irq_level
);
    import frcp_pkg::*;

    localparam int AW    = $clog2(ROM_DEPTH);
    localparam int IDX_W = $clog2(GLYPH_BYTES + 2);
    localparam int SPAN  = (END_CODE > FIRST_CODE) ? (END_CODE - FIRST_CODE) * GLYPH_BYTES : 1;
    localparam int OFS_W = $clog2(SPAN + GLYPH_BYTES + 1);

    localparam logic [IDX_W-1:0] QUEUE_TOTAL = IDX_W'(GLYPH_BYTES + 1);
    localparam logic [16:0]      FIRST_C     = 17'(FIRST_CODE);
    localparam logic [16:0]      END_C       = 17'(END_CODE);
    localparam logic [AW-1:0]    LAST_ADDR   = AW'(ROM_DEPTH - 1);

    // command and queue state
    t_cmd_phase       r_cmd, n_cmd;
    logic [7:0]       r_code_low, n_code_low;
    logic [OFS_W-1:0] r_glyph_ofs, n_glyph_ofs;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0] r_total, n_total;
    logic [7:0]       r_status, n_status;
    logic             r_irq, n_irq;

    // ROM fill after reset
    logic             r_clr_busy;
    logic [AW-1:0]    r_clr_addr;

    // middle stage and output register
    logic             r_p_valid;
    logic             r_p_rom;
    logic [7:0]       r_p_data;
    logic             r_p_irq;
    logic             r_o_valid;
    logic [7:0]       r_o_data;
    logic             r_o_irq;

    logic             accept;
    logic             p_move;
    logic             use_rom;
    logic [7:0]       rd_val;
    logic [OFS_W-1:0] ofs_sum;
    logic [AW-1:0]    rom_raddr;
    logic [7:0]       rom_rdata;
    logic [16:0]      code;
    logic [15:0]      code_diff;

    // handshake
    assign p_move  = r_p_valid && (!r_o_valid || !i_stall);
    assign o_stall = r_clr_busy || (r_p_valid && !p_move);
    assign accept  = i_valid && !o_stall;

    // glyph byte address and code arithmetic
    assign ofs_sum   = r_glyph_ofs + OFS_W'(r_rd_idx) - OFS_W'(1);
    assign rom_raddr = AW'(ofs_sum);
    assign code      = {1'b0, i_write_data, r_code_low};
    assign code_diff = code[15:0] - FIRST_C[15:0];

    // next state for one request
    always_comb begin
        n_cmd       = r_cmd;
        n_code_low  = r_code_low;
        n_glyph_ofs = r_glyph_ofs;
        n_rd_idx    = r_rd_idx;
        n_total     = r_total;
        n_status    = r_status;
        n_irq       = r_irq;
        rd_val      = EMPTY_READ;
        use_rom     = 1'b0;
        if (accept) begin
            if (i_action == ACT_READ) begin
                priority if (i_port == PORT_DATA) begin
                    // pop the queue
                    if (r_rd_idx < r_total) begin
                        if (r_rd_idx == '0) begin
                            rd_val = HEADER_BYTE;
                        end else if (32'(ofs_sum) < 32'(ROM_DEPTH)) begin
                            use_rom = 1'b1;
                        end else begin
                            rd_val = ROM_FILL;
                        end
                        n_rd_idx = r_rd_idx + IDX_W'(1);
                    end
                    if (n_rd_idx >= r_total) begin
                        n_status = STATUS_IDLE;
                    end
                end else if (i_port == PORT_STATUS) begin
                    n_irq  = 1'b0;
                    rd_val = r_status;
                end else begin
                    rd_val = OTHER_READ;
                end
            end else begin
                priority if (i_port == PORT_DATA) begin
                    unique case (r_cmd)
                        CMD_MODE: n_cmd = CMD_LOW;
                        CMD_LOW: begin
                            n_code_low = i_write_data;
                            n_cmd      = CMD_HIGH;
                        end
                        CMD_HIGH: begin
                            n_cmd = CMD_MODE;
                            if (code >= FIRST_C && code < END_C) begin
                                n_glyph_ofs = OFS_W'(32'(code_diff) * 32'(GLYPH_BYTES));
                                n_rd_idx    = '0;
                                n_total     = QUEUE_TOTAL;
                                n_status    = STATUS_READY;
                                n_irq       = 1'b1;
                            end else begin
                                n_status = STATUS_ERROR;
                            end
                        end
                        default: n_cmd = CMD_MODE;
                    endcase
                end else if (i_port == PORT_STATUS) begin
                    n_irq = 1'b1;
                end else begin
                    n_irq = r_irq;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd      <= CMD_MODE;
            r_rd_idx   <= '0;
            r_total    <= '0;
            r_status   <= STATUS_IDLE;
            r_irq      <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_p_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_cmd    <= n_cmd;
            r_rd_idx <= n_rd_idx;
            r_total  <= n_total;
            r_status <= n_status;
            r_irq    <= n_irq;
            // ROM fill sweep
            if (r_clr_busy) begin
                if (r_clr_addr == LAST_ADDR) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
            end
            // middle stage
            if (accept) begin
                r_p_valid <= 1'b1;
            end else if (p_move) begin
                r_p_valid <= 1'b0;
            end
            // output register
            if (p_move) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_code_low  <= n_code_low;
        r_glyph_ofs <= n_glyph_ofs;
        if (accept) begin
            r_p_rom  <= use_rom;
            r_p_data <= rd_val;
            r_p_irq  <= n_irq;
        end
        if (p_move) begin
            r_o_data <= r_p_rom ? rom_rdata : r_p_data;
            r_o_irq  <= r_p_irq;
        end
    end

    // font ROM
    frcp_ram #(
        .WIDTH(8),
        .DEPTH(ROM_DEPTH)
    ) u_font_rom (
        .i_clk  (i_clk),
        .i_we   (r_clr_busy),
        .i_waddr(r_clr_addr),
        .i_wdata(ROM_FILL),
        .i_re   (accept),
        .i_raddr(rom_raddr),
        .o_rdata(rom_rdata)
    );

    assign o_valid     = r_o_valid;
    assign o_read_data = r_o_data;
    assign o_irq_level = r_o_irq;

endmodule
